// ===== rtl/gnfsp_pkg.sv =====
package gnfsp_pkg;

    localparam int MaxSlots     = 64;
    localparam int InitialCount = 10;
    localparam int SlotW        = 6;
    localparam int SizeW        = 7;
    localparam int CntW         = 32;
    localparam int CfgW         = 7;
    localparam int AvailCap     = 64;
    localparam int ApbAddrW     = 4;
    localparam int ApbDataW     = 32;

    // An initial count of one or less falls back to ten slots.
    localparam int InitBase = (InitialCount > 1) ? InitialCount : 10;
    localparam int InitSize = (InitBase > MaxSlots) ? MaxSlots : InitBase;

    localparam logic [CfgW-1:0] SoftLimitRst = CfgW'(64);
    localparam logic [CfgW-1:0] HardLimitRst = CfgW'(64);
    localparam logic [CfgW-1:0] GrowStepRst  = CfgW'(8);

    typedef enum logic {
        CMD_ALLOC   = 1'b0,
        CMD_RELEASE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        REG_SOFT_LIMIT = 2'd0,
        REG_HARD_LIMIT = 2'd1,
        REG_GROW_STEP  = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [CfgW-1:0] soft_limit;
        logic [CfgW-1:0] hard_limit;
        logic [CfgW-1:0] grow_step;
    } t_cfg;

    typedef struct packed {
        logic             we;
        logic [SlotW-1:0] waddr;
        logic             wdata;
        logic             re;
        logic [SlotW-1:0] raddr;
    } t_mem_req;

    function automatic logic [SizeW-1:0] f_soft_eff(t_cfg c);
        logic [SizeW-1:0] init;
        init = SizeW'(InitSize);
        return (c.soft_limit < init) ? init : c.soft_limit;
    endfunction

    function automatic logic [SizeW-1:0] f_hard_eff(t_cfg c);
        logic [SizeW-1:0] s;
        logic [SizeW-1:0] h;
        s = f_soft_eff(c);
        h = (c.hard_limit < s) ? s : c.hard_limit;
        return (h > SizeW'(MaxSlots)) ? SizeW'(MaxSlots) : h;
    endfunction

    // Step the rotating pointer, wrapping at the active pool size.
    function automatic logic [SlotW-1:0] f_advance(logic [SlotW-1:0] x,
                                                   logic [SizeW-1:0] pool);
        logic [SizeW-1:0] nx;
        nx = {1'b0, x} + SizeW'(1);
        return (nx >= pool) ? '0 : nx[SlotW-1:0];
    endfunction

    // Pool size minus outstanding slots, saturated to zero and AvailCap.
    function automatic logic [SizeW-1:0] f_available(logic [SizeW-1:0] pool,
                                                     logic [CntW-1:0]  outst);
        logic [CntW+1:0]  a;
        logic [SizeW-1:0] res;
        a = {{(CntW+2-SizeW){1'b0}}, pool} - {{2{outst[CntW-1]}}, outst};
        if (a[CntW+1]) begin
            res = '0;
        end else if (a[CntW:0] > (CntW+1)'(AvailCap)) begin
            res = SizeW'(AvailCap);
        end else begin
            res = a[SizeW-1:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/growable_next_fit_slot_pool_unit.sv =====
// Release: handled from idle without a scan; the result strobe comes the cycle after start.
// Allocate: the scan starts at the rotating pointer and probes up to the whole pool;
// the mark memory is probed one slot per cycle through its single read port.
// A failed scan below the hard limit grows the pool and grants the first new slot.
// After reset the mark memory is cleared one slot per cycle; busy stays high until it is clear.
// The receiver cannot stall: o_done is high for one cycle; the result fields stay held.
module growable_next_fit_slot_pool_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gnfsp_pkg::ApbAddrW-1:0]  paddr,
    input  logic [gnfsp_pkg::ApbDataW-1:0]  pwdata,
    output logic [gnfsp_pkg::ApbDataW-1:0]  prdata,
    output logic                            pready,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_cmd,
    input  logic [gnfsp_pkg::SlotW-1:0]     i_slot_to_free,
    output logic                            o_done,
    output logic                            o_ok,
    output logic [gnfsp_pkg::SlotW-1:0]     o_granted_slot,
    output logic                            o_soft_over,
    output logic                            o_hard_full,
    output logic [gnfsp_pkg::SizeW-1:0]     o_pool_now,
    output logic [gnfsp_pkg::CntW-1:0]      o_alloc_total,
    output logic [gnfsp_pkg::SizeW-1:0]     o_available
);
    import gnfsp_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_SCAN  = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [SlotW-1:0] r_clr_idx, n_clr_idx;
    logic [SizeW-1:0] r_pool, n_pool;
    logic [SlotW-1:0] r_next, n_next;
    logic [CntW-1:0]  r_alloc, n_alloc;
    logic [CntW-1:0]  r_outst, n_outst;
    logic [SlotW-1:0] r_probe, n_probe;
    logic [SizeW-1:0] r_issued, n_issued;
    logic [SizeW-1:0] r_checked, n_checked;
    logic             r_pend, n_pend;
    logic [SlotW-1:0] r_pend_idx, n_pend_idx;
    logic             r_done, n_done;
    logic             r_ok, n_ok;
    logic [SlotW-1:0] r_granted, n_granted;
    logic             r_soft_over, n_soft_over;
    logic             r_hard_full, n_hard_full;

    t_cfg             cfg;
    t_mem_req         mem_req;
    logic             mem_rdata;
    logic             hit;
    logic             miss;
    logic [SizeW-1:0] hard_eff;
    logic [SizeW-1:0] step;
    logic [SizeW:0]   grown_sum;
    logic [SizeW-1:0] grown;

    gnfsp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    gnfsp_mark_ram u_marks (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    assign hard_eff  = f_hard_eff(cfg);
    assign step      = (cfg.grow_step == '0) ? SizeW'(1) : cfg.grow_step;
    assign grown_sum = {1'b0, r_pool} + {1'b0, step};
    assign grown     = (grown_sum > {1'b0, hard_eff}) ? hard_eff : grown_sum[SizeW-1:0];

    // A probe result of zero means the slot is free.
    assign hit  = r_pend && !mem_rdata;
    assign miss = r_pend && mem_rdata && ((r_checked + SizeW'(1)) == r_pool);

    always_comb begin
        n_state     = r_state;
        n_clr_idx   = r_clr_idx;
        n_pool      = r_pool;
        n_next      = r_next;
        n_alloc     = r_alloc;
        n_outst     = r_outst;
        n_probe     = r_probe;
        n_issued    = r_issued;
        n_checked   = r_checked;
        n_pend      = 1'b0;
        n_pend_idx  = r_pend_idx;
        n_done      = 1'b0;
        n_ok        = r_ok;
        n_granted   = r_granted;
        n_soft_over = r_soft_over;
        n_hard_full = r_hard_full;
        mem_req     = '0;

        unique case (r_state)
            S_CLEAR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_clr_idx;
                mem_req.wdata = 1'b0;
                n_clr_idx     = r_clr_idx + SlotW'(1);
                if (r_clr_idx == SlotW'(MaxSlots - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    if (i_cmd == CMD_RELEASE) begin
                        n_done      = 1'b1;
                        n_granted   = '0;
                        n_soft_over = 1'b0;
                        n_hard_full = 1'b0;
                        n_ok        = 1'b0;
                        if ({1'b0, i_slot_to_free} < r_pool) begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = i_slot_to_free;
                            mem_req.wdata = 1'b0;
                            n_outst       = r_outst - CntW'(1);
                            n_ok          = 1'b1;
                        end
                    end else begin
                        n_state   = S_SCAN;
                        n_probe   = r_next;
                        n_issued  = '0;
                        n_checked = '0;
                    end
                end
            end
            S_SCAN: begin
                // Reads run one ahead of the check; no new read is issued in the cycle
                // that finds a free slot or ends the scan.
                if (!hit && !miss && (r_issued < r_pool)) begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = r_probe;
                    n_probe       = f_advance(r_probe, r_pool);
                    n_issued      = r_issued + SizeW'(1);
                    n_pend        = 1'b1;
                    n_pend_idx    = r_probe;
                end
                if (r_pend) begin
                    n_checked = r_checked + SizeW'(1);
                end
                if (hit) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = r_pend_idx;
                    mem_req.wdata = 1'b1;
                    n_next        = f_advance(r_pend_idx, r_pool);
                    n_alloc       = r_alloc + CntW'(1);
                    n_outst       = r_outst + CntW'(1);
                    n_ok          = 1'b1;
                    n_granted     = r_pend_idx;
                    n_soft_over   = 1'b0;
                    n_hard_full   = 1'b0;
                    n_done        = 1'b1;
                    n_state       = S_IDLE;
                end else if (miss) begin
                    n_soft_over = (r_pool >= f_soft_eff(cfg));
                    n_done      = 1'b1;
                    n_state     = S_IDLE;
                    if (r_pool < hard_eff) begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = r_pool[SlotW-1:0];
                        mem_req.wdata = 1'b1;
                        n_pool        = grown;
                        n_next        = f_advance(r_pool[SlotW-1:0], grown);
                        n_alloc       = r_alloc + CntW'(1);
                        n_outst       = r_outst + CntW'(1);
                        n_ok          = 1'b1;
                        n_granted     = r_pool[SlotW-1:0];
                        n_hard_full   = 1'b0;
                    end else begin
                        n_ok        = 1'b0;
                        n_granted   = '0;
                        n_hard_full = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_idx <= '0;
            r_pool    <= SizeW'(InitSize);
            r_next    <= '0;
            r_alloc   <= '0;
            r_outst   <= '0;
            r_pend    <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_pool    <= n_pool;
            r_next    <= n_next;
            r_alloc   <= n_alloc;
            r_outst   <= n_outst;
            r_pend    <= n_pend;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_probe     <= n_probe;
        r_issued    <= n_issued;
        r_checked   <= n_checked;
        r_pend_idx  <= n_pend_idx;
        r_ok        <= n_ok;
        r_granted   <= n_granted;
        r_soft_over <= n_soft_over;
        r_hard_full <= n_hard_full;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_ok           = r_ok;
    assign o_granted_slot = r_granted;
    assign o_soft_over    = r_soft_over;
    assign o_hard_full    = r_hard_full;
    assign o_pool_now     = r_pool;
    assign o_alloc_total  = r_alloc;
    assign o_available    = f_available(r_pool, r_outst);

    a_fail_not_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_hard_full |-> !o_ok)
        else $error("hard_full reported together with ok");

    a_grant_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_ok |-> ({1'b0, o_granted_slot} < o_pool_now))
        else $error("granted slot outside the active pool");

    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_issued <= r_pool) && (r_checked <= r_issued))
        else $error("scan probed more slots than the pool holds");

    a_scan_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) && (n_state == S_IDLE) |=> o_done)
        else $error("scan ended without a result strobe");

    a_pool_grows_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_pool >= $past(r_pool)))
        else $error("pool size shrank");

endmodule

// ===== rtl/gnfsp_mark_ram.sv =====
module gnfsp_mark_ram (
    input  logic                i_clk,
    input  gnfsp_pkg::t_mem_req i_req,
    output logic                o_rdata
);
    import gnfsp_pkg::*;

    logic r_mem [MaxSlots];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/gnfsp_cfg.sv =====
module gnfsp_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [gnfsp_pkg::ApbAddrW-1:0]    paddr,
    input  logic [gnfsp_pkg::ApbDataW-1:0]    pwdata,
    output logic [gnfsp_pkg::ApbDataW-1:0]    prdata,
    output logic                              pready,
    output gnfsp_pkg::t_cfg                   o_cfg
);
    import gnfsp_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[ApbAddrW-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_SOFT_LIMIT: n_cfg.soft_limit = pwdata[CfgW-1:0];
                REG_HARD_LIMIT: n_cfg.hard_limit = pwdata[CfgW-1:0];
                REG_GROW_STEP:  n_cfg.grow_step  = pwdata[CfgW-1:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SOFT_LIMIT: prdata = ApbDataW'(r_cfg.soft_limit);
            REG_HARD_LIMIT: prdata = ApbDataW'(r_cfg.hard_limit);
            REG_GROW_STEP:  prdata = ApbDataW'(r_cfg.grow_step);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.soft_limit <= SoftLimitRst;
            r_cfg.hard_limit <= HardLimitRst;
            r_cfg.grow_step  <= GrowStepRst;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    import gnfsp_pkg::*;

    typedef struct packed {
        t_cmd             cmd;
        logic [SlotW-1:0] slot;
    } t_pool_cmd;

    typedef struct packed {
        logic             ok;
        logic [SlotW-1:0] granted;
        logic             soft_over;
        logic             hard_full;
        logic [SizeW-1:0] pool_now;
        logic [CntW-1:0]  alloc_total;
        logic [SizeW-1:0] available;
    } t_pool_result;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                psel           = 1'b0;
    logic                penable        = 1'b0;
    logic                pwrite         = 1'b0;
    logic [ApbAddrW-1:0] paddr          = '0;
    logic [ApbDataW-1:0] pwdata         = '0;
    logic [ApbDataW-1:0] prdata;
    logic                pready;
    logic                start          = 1'b0;
    logic                busy;
    logic                i_cmd          = 1'b0;
    logic [SlotW-1:0]    i_slot_to_free = '0;
    logic                o_done;
    logic                o_ok;
    logic [SlotW-1:0]    o_granted_slot;
    logic                o_soft_over;
    logic                o_hard_full;
    logic [SizeW-1:0]    o_pool_now;
    logic [CntW-1:0]     o_alloc_total;
    logic [SizeW-1:0]    o_available;

    // Shadow of the pool: marks, active size, rotating pointer, counters, registers.
    logic [MaxSlots-1:0] mark_used;
    int                  pool_sz;
    int                  scan_ptr;
    logic [CntW-1:0]     grants;
    logic [CntW-1:0]     releases;
    logic [CfgW-1:0]     cfg_reg [3];

    t_pool_cmd           pending_cmds [$];
    t_pool_result        awaited_results [$];
    t_pool_cmd           drv_item;
    t_pool_result        want;
    int                  send_idle_pct = 0;
    int                  mismatches    = 0;

    growable_next_fit_slot_pool_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_slot_to_free (i_slot_to_free),
        .o_done         (o_done),
        .o_ok           (o_ok),
        .o_granted_slot (o_granted_slot),
        .o_soft_over    (o_soft_over),
        .o_hard_full    (o_hard_full),
        .o_pool_now     (o_pool_now),
        .o_alloc_total  (o_alloc_total),
        .o_available    (o_available)
    );

    always #1 i_clk = ~i_clk;

    function automatic int soft_floor();
        return (int'(cfg_reg[REG_SOFT_LIMIT]) < InitSize) ? InitSize
                                                          : int'(cfg_reg[REG_SOFT_LIMIT]);
    endfunction

    function automatic int hard_cap();
        int h;
        h = (int'(cfg_reg[REG_HARD_LIMIT]) < soft_floor()) ? soft_floor()
                                                           : int'(cfg_reg[REG_HARD_LIMIT]);
        return (h > MaxSlots) ? MaxSlots : h;
    endfunction

    function automatic int wrap_next(int p);
        return (p + 1 >= pool_sz) ? 0 : p + 1;
    endfunction

    function automatic t_pool_result apply_pool_cmd(t_cmd cmd, logic [SlotW-1:0] slot);
        t_pool_result r;
        int           probes;
        int           idx;
        int           step;
        int           diff;
        longint       avail;
        r = '0;
        if (cmd == CMD_RELEASE) begin
            if (int'(slot) < pool_sz) begin
                mark_used[slot] = 1'b0;
                releases++;
                r.ok = 1'b1;
            end
        end else begin
            for (probes = 0; probes < pool_sz && !r.ok; probes++) begin
                idx = scan_ptr;
                scan_ptr = wrap_next(scan_ptr);
                if (!mark_used[idx]) begin
                    mark_used[idx] = 1'b1;
                    r.granted = idx[SlotW-1:0];
                    r.ok = 1'b1;
                end
            end
            if (!r.ok) begin
                if (pool_sz >= soft_floor()) begin
                    r.soft_over = 1'b1;
                end
                if (pool_sz < hard_cap()) begin
                    // A zero step still grows the pool by one slot.
                    step = (cfg_reg[REG_GROW_STEP] == '0) ? 1 : int'(cfg_reg[REG_GROW_STEP]);
                    scan_ptr = pool_sz;
                    pool_sz = (pool_sz + step > hard_cap()) ? hard_cap() : pool_sz + step;
                    mark_used[scan_ptr] = 1'b1;
                    r.granted = scan_ptr[SlotW-1:0];
                    r.ok = 1'b1;
                    scan_ptr = wrap_next(scan_ptr);
                end else begin
                    r.hard_full = 1'b1;
                end
            end
            if (r.ok) begin
                grants++;
            end
        end
        // Outstanding slots are the counter difference read as a signed 32-bit value.
        diff = grants - releases;
        avail = longint'(pool_sz) - longint'(diff);
        if (avail < 0) begin
            avail = 0;
        end
        if (avail > AvailCap) begin
            avail = AvailCap;
        end
        r.pool_now    = SizeW'(pool_sz);
        r.alloc_total = grants;
        r.available   = SizeW'(avail);
        return r;
    endfunction

    task automatic check_field(string what, logic [63:0] exp_val, logic [63:0] got_val);
        if (exp_val !== got_val) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch on %s: expected %0d, got %0d", what, exp_val, got_val);
            end
        end
    endtask

    // Driver: an offered transaction is held until the block takes it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                awaited_results.push_back(apply_pool_cmd(t_cmd'(i_cmd), i_slot_to_free));
            end
            if (!start || !busy) begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    drv_item = pending_cmds.pop_front();
                    start          <= 1'b1;
                    i_cmd          <= drv_item.cmd;
                    i_slot_to_free <= drv_item.slot;
                end else begin
                    start          <= 1'b0;
                    i_cmd          <= 1'($urandom);
                    i_slot_to_free <= SlotW'($urandom);
                end
            end
        end
    end

    // Monitor: every strobed result is matched against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result strobed with no command outstanding");
                end
            end else begin
                want = awaited_results.pop_front();
                check_field("ok", want.ok, o_ok);
                check_field("granted_slot", want.granted, o_granted_slot);
                check_field("soft_over", want.soft_over, o_soft_over);
                check_field("hard_full", want.hard_full, o_hard_full);
                check_field("pool_now", want.pool_now, o_pool_now);
                check_field("alloc_total", want.alloc_total, o_alloc_total);
                check_field("available", want.available, o_available);
            end
        end
    end

    task automatic reg_access(t_reg_idx idx, logic wr, logic [ApbDataW-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ApbAddrW'(4 * int'(idx));
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (wr) begin
            cfg_reg[idx] = data[CfgW-1:0];
        end else begin
            check_field("register readback", cfg_reg[idx], prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_reg(t_reg_idx idx, logic [ApbDataW-1:0] data);
        reg_access(idx, 1'b1, data);
        reg_access(idx, 1'b0, '0);
    endtask

    task automatic set_limits(logic [ApbDataW-1:0] soft_val, logic [ApbDataW-1:0] hard_val,
                              logic [ApbDataW-1:0] grow_val);
        set_reg(REG_SOFT_LIMIT, soft_val);
        set_reg(REG_HARD_LIMIT, hard_val);
        set_reg(REG_GROW_STEP, grow_val);
    endtask

    task automatic queue_cmd(t_cmd cmd, logic [SlotW-1:0] slot);
        t_pool_cmd c;
        c.cmd  = cmd;
        c.slot = slot;
        pending_cmds.push_back(c);
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_cmds.size() != 0 || start || busy || awaited_results.size() != 0);
    endtask

    // Mostly single commands, with bursts of allocations to drive the pool to exhaustion.
    task automatic run_random(int n, int idle_pct);
        int lim;
        int k;
        int burst;
        lim = (pool_sz > hard_cap()) ? pool_sz : hard_cap();
        send_idle_pct = idle_pct;
        k = 0;
        while (k < n) begin
            if ($urandom_range(99) < 10) begin
                burst = $urandom_range(12, 2);
                repeat (burst) queue_cmd(CMD_ALLOC, SlotW'($urandom));
                k += burst;
            end else if ($urandom_range(1, 0) == 0) begin
                queue_cmd(CMD_ALLOC, SlotW'($urandom));
                k++;
            end else if ($urandom_range(99) < 80) begin
                queue_cmd(CMD_RELEASE, SlotW'($urandom_range(lim - 1, 0)));
                k++;
            end else begin
                queue_cmd(CMD_RELEASE, SlotW'($urandom));
                k++;
            end
        end
        wait_idle();
    endtask

    initial begin
        mark_used = '0;
        pool_sz   = InitSize;
        scan_ptr  = 0;
        grants    = '0;
        releases  = '0;
        cfg_reg[REG_SOFT_LIMIT] = SoftLimitRst;
        cfg_reg[REG_HARD_LIMIT] = HardLimitRst;
        cfg_reg[REG_GROW_STEP]  = GrowStepRst;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_idle();

        reg_access(REG_SOFT_LIMIT, 1'b0, '0);
        reg_access(REG_HARD_LIMIT, 1'b0, '0);
        reg_access(REG_GROW_STEP, 1'b0, '0);

        // Fill the initial pool, grow it once, then release out of range, twice the
        // same slot, and a slot that was never taken.
        repeat (11) queue_cmd(CMD_ALLOC, '1);
        queue_cmd(CMD_RELEASE, 6'd63);
        queue_cmd(CMD_RELEASE, 6'd0);
        queue_cmd(CMD_RELEASE, 6'd0);
        queue_cmd(CMD_RELEASE, 6'd17);
        queue_cmd(CMD_ALLOC, '0);
        wait_idle();

        // Hard limit below the current pool size and a zero step: the pool fills and
        // the next allocation fails with both flags.
        set_limits(32'd0, 32'd0, 32'd0);
        repeat (8) queue_cmd(CMD_ALLOC, '0);
        queue_cmd(CMD_RELEASE, 6'd5);
        queue_cmd(CMD_ALLOC, '1);
        wait_idle();

        set_limits(32'd20, 32'd40, 32'd0);
        run_random(185, 23);
        set_limits(32'd1, 32'd1, 32'd1);
        run_random(185, 23);
        set_limits(32'd45, 32'd56, 32'd5);
        run_random(185, 56);
        set_limits(32'd127, 32'd127, 32'd127);
        run_random(185, 56);
        // Upper data bits are set; only the low seven bits land in each register.
        set_limits(32'hFFFF_FFC0, 32'h8000_0040, 32'hABCD_EF40);
        run_random(185, 0);
        set_limits(32'd0, 32'd100, 32'd2);
        run_random(185, 0);

        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("growable_next_fit_slot_pool_unit verification clean");
        end else begin
            $display("growable_next_fit_slot_pool_unit verification failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("growable_next_fit_slot_pool_unit verification failed");
        $finish;
    end

endmodule
